/* rtl/core/igfc_pkg.sv */
// Shared types and constants for the idle-gap frame capture block.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package igfc_pkg;

   // Sizing
   localparam int FRAME_MAX_BYTES = 256;
   localparam int RING_SLOTS      = 8;

   localparam int CNT_W   = $clog2(FRAME_MAX_BYTES + 1);
   localparam int AIDX_W  = (FRAME_MAX_BYTES > 1) ? $clog2(FRAME_MAX_BYTES) : 1;
   localparam int SLOT_W  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
   localparam int RING_AW = $clog2(RING_SLOTS * FRAME_MAX_BYTES);

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPTURE_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_MS         = 1'd1;
   localparam logic [15:0]          GAP_MS_RESET       = 16'd20;

   // Action codes
   localparam logic [1:0] ACT_TICK   = 2'd0;
   localparam logic [1:0] ACT_BYTE   = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Result kinds
   localparam logic EVT_CLOSE = 1'b0;
   localparam logic EVT_READ  = 1'b1;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  data_byte;
      logic [31:0] now_ms;
      logic [2:0]  read_slot;
      logic [7:0]  read_index;
   } req_type;

   typedef struct packed {
      logic        event_kind;
      logic [2:0]  slot;
      logic [8:0]  frame_length;
      logic [31:0] frame_time_ms;
      logic [31:0] frames_total;
      logic [7:0]  read_data;
   } rsp_type;

   // Work handed from the front end to the back end
   typedef struct packed {
      logic              do_close;
      logic              do_store;
      logic              do_read;
      logic [SLOT_W-1:0] slot_idx;
      logic [CNT_W-1:0]  len;
      logic [31:0]       time_ms;
      logic [31:0]       total;
      logic [AIDX_W-1:0] store_idx;
      logic [7:0]        data_byte;
      logic [2:0]        rd_slot;
      logic [7:0]        read_index;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_COPY,
      BK_CLOSE_RESP,
      BK_STORE,
      BK_READ_MEM,
      BK_READ_RESP
   } back_state_type;

endpackage

`default_nettype wire

/* rtl/core/igfc_cmd_queue.sv */
// Two-entry command queue between front end and back end.
// Depends on igfc_pkg for cmd_type.
`default_nettype none

module igfc_cmd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire igfc_pkg::cmd_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output igfc_pkg::cmd_type     pop_data,
   output logic                  empty
);

   igfc_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/igfc_front.sv */
// Front end: configuration registers, gap and full detection, frame bookkeeping;
// turns each accepted item needing back-end work into a command. Uses igfc_pkg.
`default_nettype none

module igfc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   input  wire logic [igfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [igfc_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                          accept,
   input  wire igfc_pkg::req_type             req,
   output logic                               q_push,
   output igfc_pkg::cmd_type                  q_cmd
);

   logic                       cap_en_ff, cap_en_in;
   logic [15:0]                gap_ff, gap_in;
   logic [igfc_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [31:0]                last_ff, last_in;
   logic [igfc_pkg::SLOT_W-1:0] head_ff, head_in;
   logic [31:0]                total_ff, total_in;

   logic [31:0] idle_ms;
   logic        gap_hit;
   logic        count_nz;
   logic        frame_full;
   logic        do_close;

   assign idle_ms    = req.now_ms - last_ff;
   assign gap_hit    = (idle_ms >= {16'd0, gap_ff});
   assign count_nz   = (count_ff != '0);
   assign frame_full = (32'(count_ff) >= igfc_pkg::FRAME_MAX_BYTES);

   always_comb begin
      cap_en_in = cap_en_ff;
      gap_in    = gap_ff;
      count_in  = count_ff;
      last_in   = last_ff;
      head_in   = head_ff;
      total_in  = total_ff;
      do_close  = 1'b0;

      q_cmd            = '0;
      q_cmd.slot_idx   = head_ff;
      q_cmd.len        = count_ff;
      q_cmd.time_ms    = last_ff;
      q_cmd.total      = total_ff + 32'd1;
      q_cmd.data_byte  = req.data_byte;
      q_cmd.rd_slot    = req.read_slot;
      q_cmd.read_index = req.read_index;

      if (csr_valid) begin
         unique case (csr_index)
            igfc_pkg::CSR_CAPTURE_ENABLE: cap_en_in = csr_wdata[0];
            igfc_pkg::CSR_GAP_MS:         gap_in    = csr_wdata[15:0];
            default:                      ;
         endcase
      end

      if (accept) begin
         unique case (req.action)
            igfc_pkg::ACT_READ: begin
               q_cmd.do_read = 1'b1;
               q_cmd.total   = total_ff;
            end
            igfc_pkg::ACT_TICK: begin
               do_close = cap_en_ff && count_nz && gap_hit;
            end
            igfc_pkg::ACT_BYTE: begin
               if (cap_en_ff) begin
                  // a reached gap empties the buffer, so a full close cannot follow
                  do_close        = count_nz && (gap_hit || frame_full);
                  q_cmd.do_store  = 1'b1;
                  q_cmd.store_idx = do_close ? '0 : count_ff[igfc_pkg::AIDX_W-1:0];
                  count_in        = do_close ? igfc_pkg::CNT_W'(1) : count_ff + 1'b1;
                  last_in         = req.now_ms;
               end
            end
            igfc_pkg::ACT_UNUSED: ;
            default: ;
         endcase
      end

      if (do_close) begin
         q_cmd.do_close = 1'b1;
         head_in  = (32'(head_ff) == igfc_pkg::RING_SLOTS - 1) ? '0 : head_ff + 1'b1;
         total_in = total_ff + 32'd1;
         if (!q_cmd.do_store) begin
            count_in = '0;
         end
      end

      q_push = q_cmd.do_close || q_cmd.do_store || q_cmd.do_read;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_en_ff <= 1'b0;
         gap_ff    <= igfc_pkg::GAP_MS_RESET;
         count_ff  <= '0;
         last_ff   <= 32'd0;
         head_ff   <= '0;
         total_ff  <= 32'd0;
      end else begin
         cap_en_ff <= cap_en_in;
         gap_ff    <= gap_in;
         count_ff  <= count_in;
         last_ff   <= last_in;
         head_ff   <= head_in;
         total_ff  <= total_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/igfc_back.sv */
// Back end: assembly buffer and frame ring memories, slot length/time table,
// frame copy sequencer and result register. Uses igfc_pkg.
`default_nettype none

module igfc_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   input  wire igfc_pkg::cmd_type q_dout,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output igfc_pkg::rsp_type     rsp_data
);

   igfc_pkg::back_state_type state_ff, state_in;
   igfc_pkg::cmd_type        cmd_ff;

   logic [7:0] asm_mem  [igfc_pkg::FRAME_MAX_BYTES];
   logic [7:0] ring_mem [igfc_pkg::RING_SLOTS * igfc_pkg::FRAME_MAX_BYTES];

   logic [igfc_pkg::CNT_W-1:0] ring_len_ff  [igfc_pkg::RING_SLOTS];
   logic [31:0]                ring_time_ff [igfc_pkg::RING_SLOTS];

   logic [igfc_pkg::CNT_W-1:0]   copy_rd_ff;
   logic                         wr_vld_ff;
   logic [igfc_pkg::AIDX_W-1:0]  wr_idx_ff;
   logic [7:0]                   asm_rdata_ff;
   logic [7:0]                   ring_rdata_ff;
   logic [igfc_pkg::CNT_W-1:0]   rd_len_ff;
   logic [31:0]                  rd_time_ff;
   logic                         rd_ok_ff;
   igfc_pkg::rsp_type            rsp_ff, rsp_in;
   logic                         rsp_vld_ff;

   logic                         copy_go;
   logic                         rsp_load;
   logic                         asm_wr;
   logic                         ring_rd;
   logic [igfc_pkg::RING_AW-1:0] copy_base;
   logic [igfc_pkg::RING_AW-1:0] rd_addr;
   logic [igfc_pkg::SLOT_W-1:0]  rd_slot;
   logic                         rd_slot_ok;
   logic                         rd_idx_ok;

   assign rd_slot    = igfc_pkg::SLOT_W'(cmd_ff.rd_slot);
   assign rd_slot_ok = (32'(cmd_ff.rd_slot) < igfc_pkg::RING_SLOTS);
   assign rd_idx_ok  = (32'(cmd_ff.read_index) < 32'(ring_len_ff[rd_slot]))
                    && (32'(cmd_ff.read_index) < igfc_pkg::FRAME_MAX_BYTES);
   assign copy_base  = igfc_pkg::RING_AW'(cmd_ff.slot_idx)
                     * igfc_pkg::RING_AW'(igfc_pkg::FRAME_MAX_BYTES);
   assign rd_addr    = igfc_pkg::RING_AW'(rd_slot)
                     * igfc_pkg::RING_AW'(igfc_pkg::FRAME_MAX_BYTES)
                     + igfc_pkg::RING_AW'(igfc_pkg::AIDX_W'(cmd_ff.read_index));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         igfc_pkg::BK_IDLE: begin
            if (!q_empty) begin
               if (q_dout.do_close) begin
                  state_in = igfc_pkg::BK_COPY;
               end else if (q_dout.do_store) begin
                  state_in = igfc_pkg::BK_STORE;
               end else if (q_dout.do_read) begin
                  state_in = igfc_pkg::BK_READ_MEM;
               end
            end
         end
         igfc_pkg::BK_COPY: begin
            if (copy_rd_ff == cmd_ff.len) begin
               state_in = igfc_pkg::BK_CLOSE_RESP;
            end
         end
         igfc_pkg::BK_CLOSE_RESP: begin
            if (rsp_load) begin
               state_in = cmd_ff.do_store ? igfc_pkg::BK_STORE : igfc_pkg::BK_IDLE;
            end
         end
         igfc_pkg::BK_STORE:     state_in = igfc_pkg::BK_IDLE;
         igfc_pkg::BK_READ_MEM:  state_in = igfc_pkg::BK_READ_RESP;
         igfc_pkg::BK_READ_RESP: begin
            if (rsp_load) begin
               state_in = igfc_pkg::BK_IDLE;
            end
         end
         default: state_in = igfc_pkg::BK_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      q_pop    = 1'b0;
      copy_go  = 1'b0;
      rsp_load = 1'b0;
      asm_wr   = 1'b0;
      ring_rd  = 1'b0;
      rsp_in   = '0;
      unique case (state_ff)
         igfc_pkg::BK_IDLE:  q_pop   = !q_empty;
         igfc_pkg::BK_COPY:  copy_go = (copy_rd_ff != cmd_ff.len);
         igfc_pkg::BK_CLOSE_RESP: begin
            rsp_load             = !rsp_vld_ff || rsp_pop;
            rsp_in.event_kind    = igfc_pkg::EVT_CLOSE;
            rsp_in.slot          = 3'(cmd_ff.slot_idx);
            rsp_in.frame_length  = 9'(cmd_ff.len);
            rsp_in.frame_time_ms = cmd_ff.time_ms;
            rsp_in.frames_total  = cmd_ff.total;
         end
         igfc_pkg::BK_STORE:    asm_wr  = 1'b1;
         igfc_pkg::BK_READ_MEM: ring_rd = 1'b1;
         igfc_pkg::BK_READ_RESP: begin
            rsp_load             = !rsp_vld_ff || rsp_pop;
            rsp_in.event_kind    = igfc_pkg::EVT_READ;
            rsp_in.slot          = cmd_ff.rd_slot;
            rsp_in.frame_length  = 9'(rd_len_ff);
            rsp_in.frame_time_ms = rd_time_ff;
            rsp_in.frames_total  = cmd_ff.total;
            rsp_in.read_data     = rd_ok_ff ? ring_rdata_ff : 8'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= igfc_pkg::BK_IDLE;
         copy_rd_ff <= '0;
         wr_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < igfc_pkg::RING_SLOTS; i++) begin
            ring_len_ff[i]  <= '0;
            ring_time_ff[i] <= 32'd0;
         end
      end else begin
         state_ff   <= state_in;
         wr_vld_ff  <= copy_go;
         copy_rd_ff <= (state_ff == igfc_pkg::BK_IDLE) ? '0
                     : copy_rd_ff + igfc_pkg::CNT_W'(copy_go);
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_vld_ff <= 1'b0;
         end
         if (rsp_load && state_ff == igfc_pkg::BK_CLOSE_RESP) begin
            ring_len_ff[cmd_ff.slot_idx]  <= cmd_ff.len;
            ring_time_ff[cmd_ff.slot_idx] <= cmd_ff.time_ms;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_dout;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      if (ring_rd) begin
         rd_ok_ff   <= rd_slot_ok && rd_idx_ok;
         rd_len_ff  <= rd_slot_ok ? ring_len_ff[rd_slot] : '0;
         rd_time_ff <= rd_slot_ok ? ring_time_ff[rd_slot] : 32'd0;
      end
   end

   // Assembly buffer: one write or one read per cycle
   always_ff @(posedge clock) begin
      if (asm_wr) begin
         asm_mem[cmd_ff.store_idx] <= cmd_ff.data_byte;
      end
      if (copy_go) begin
         asm_rdata_ff <= asm_mem[copy_rd_ff[igfc_pkg::AIDX_W-1:0]];
         wr_idx_ff    <= copy_rd_ff[igfc_pkg::AIDX_W-1:0];
      end
   end

   // Frame ring: copy writes follow the assembly reads in the next cycle
   always_ff @(posedge clock) begin
      if (wr_vld_ff) begin
         ring_mem[copy_base + igfc_pkg::RING_AW'(wr_idx_ff)] <= asm_rdata_ff;
      end
      if (ring_rd) begin
         ring_rdata_ff <= ring_mem[rd_addr];
      end
   end

   assign rsp_empty = !rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* rtl/core/idle_gap_frame_capture.sv */
// Idle-gap frame capture, top level: front end, command queue, back end.
// Depends on igfc_pkg, igfc_front, igfc_cmd_queue and igfc_back.
//
//  Channel  Ports                                   Beat taken when
//  req      req_push, req_full, req_data            req_push && !req_full
//  rsp      rsp_empty, rsp_pop, rsp_data            rsp_pop && !rsp_empty
//  csr      csr_valid, csr_ready, csr_index/wdata   csr_valid && csr_ready
//
// The front end decides each item in the cycle it is taken and queues at most
// one command; the two-entry queue fills only while the back end is busy.
// Back end states per command: byte store IDLE, STORE; read IDLE, READ_MEM,
// READ_RESP; frame close IDLE, COPY, CLOSE_RESP, and STORE for the closing byte.
// A result waits in the output register; the back end stalls while it is full.
// Reset is synchronous; no memory clearing is needed after reset.
`default_nettype none

module idle_gap_frame_capture (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire igfc_pkg::req_type               req_data,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output igfc_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [igfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [igfc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic              accept;
   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;
   igfc_pkg::cmd_type q_cmd;
   igfc_pkg::cmd_type q_dout;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   igfc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req       (req_data),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   igfc_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_dout),
      .empty     (q_empty)
   );

   igfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_dout    (q_dout),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // The front end only pushes on an accepted beat, which needs queue space
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into a full queue");

   // A frame close never carries an empty frame
   a_close_nonempty: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_dout.do_close) |-> (q_dout.len != '0))
      else $error("close command with zero length");

   // A read command never also closes or stores
   a_read_alone: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_dout.do_read) |-> (!q_dout.do_close && !q_dout.do_store))
      else $error("read command mixed with capture work");

   // Output register loads only when it is free or being drained
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting result dropped");

endmodule

`default_nettype wire
